// File: rtl/pcdom_pkg.sv
// Shared types and constants for the phase current DC offset monitor.
// Depends on nothing; imported by phase_current_dc_offset_monitor and its testbench.
`timescale 1ns / 1ps

package pcdom_pkg;

    localparam int SUM_W  = 32;   // running phase sums, saturating
    localparam int CNT_W  = 13;   // sample counter, wraps at 13 bits
    localparam int WIN_W  = 13;   // window length register
    localparam int INV_W  = 16;   // Q0.16 reciprocal
    localparam int THR_W  = 16;   // signed mean threshold
    localparam int DLY_W  = 16;   // on-delay length and persistence counters
    localparam int MEAN_W = 16;   // mean fields on the result beat
    localparam int CFG_W  = 16;   // configuration write data
    localparam int CFG_AW = 2;    // configuration register index
    localparam int NPH    = 3;    // phases a, b, c

    localparam int RND_SHIFT = 16;
    localparam int PROD_W    = SUM_W + INV_W + 1;

    localparam logic [WIN_W-1:0] WIN_LEN_RST  = 13'd200;
    localparam logic [INV_W-1:0] INV_WIN_RST  = 16'd328;
    localparam logic [THR_W-1:0] MEAN_THR_RST = 16'd640;
    localparam logic [DLY_W-1:0] DELAY_RST    = 16'd1000;

    typedef enum logic [CFG_AW-1:0] {
        CFG_WIN_LEN  = 2'd0,
        CFG_INV_WIN  = 2'd1,
        CFG_MEAN_THR = 2'd2,
        CFG_DELAY    = 2'd3
    } t_cfg_idx;

endpackage

// File: rtl/phase_current_dc_offset_monitor.sv
// Phase current DC offset monitor: windowed mean, threshold and on-delay fault.
// Depends on pcdom_pkg (constants, register index codes).
// Five-stage pipeline: input, accumulate, multiply, round, test and output.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// --------  ---  ------------------------  --------------------------------------------
// s stream  in   i_s_tvalid / o_s_tready   i_s_tdata: current_a, current_b, current_c
// m stream  out  o_m_tvalid / i_m_tready   o_m_tdata: means a..c, faults a..c; tuser: done
// config    in   i_cfg_we                  i_cfg_addr register index, i_cfg_wdata value
//
// One beat is accepted every clock cycle when the output side keeps up. A beat
// passes the accumulate, multiply and round registers before the output register;
// the five register stages each hold one beat, and the multiply stage sets the clock.
// Reset (synchronous, active low) clears all running sums, counters, held means, faults
// and valid bits, and loads the configuration registers with their defaults.
// A stall on the output only backs up as far as the first empty stage, so the
// input keeps taking beats until every stage holds one.

module phase_current_dc_offset_monitor #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream: current_a, current_b, current_c (SAMPLE_BITS each), lowest first
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]  i_s_tdata,
    // master stream tdata: mean_a, mean_b, mean_c (16 each), fault_a, fault_b,
    // fault_c, then zero padding
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [55:0]                         o_m_tdata,
    // master stream tuser: window_done
    output logic                                o_m_tuser,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pcdom_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [pcdom_pkg::CFG_W-1:0]         i_cfg_wdata
);

    import pcdom_pkg::*;

    localparam int PAD_W      = 56 - (NPH*MEAN_W + NPH);

    // Saturation bounds of a held mean.
    localparam logic signed [SUM_W:0] MEAN_HI =
        (33'sd1 <<< (SAMPLE_BITS-1)) - 33'sd1;
    localparam logic signed [SUM_W:0] MEAN_LO = -MEAN_HI - 33'sd1;

    // Configuration registers.
    logic        [WIN_W-1:0] r_win_len;
    logic        [INV_W-1:0] r_inv_win;
    logic signed [THR_W-1:0] r_mean_thr;
    logic        [DLY_W-1:0] r_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= WIN_LEN_RST;
            r_inv_win  <= INV_WIN_RST;
            r_mean_thr <= MEAN_THR_RST;
            r_delay    <= DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIN_LEN:  r_win_len  <= i_cfg_wdata[WIN_W-1:0];
                CFG_INV_WIN:  r_inv_win  <= i_cfg_wdata[INV_W-1:0];
                CFG_MEAN_THR: r_mean_thr <= i_cfg_wdata[THR_W-1:0];
                CFG_DELAY:    r_delay    <= i_cfg_wdata[DLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline valid bits and per-stage advance. A stage may load when it is
    // empty or when the stage after it is moving on.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !r_v5 || i_m_tready;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_s_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_s_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
        end
    end

    // Stage 1: input register.
    logic signed [SAMPLE_BITS-1:0] r_smp [NPH];

    always_ff @(posedge i_clk) begin
        if (adv1 && i_s_tvalid) begin
            for (int i = 0; i < NPH; i++) begin
                r_smp[i] <= i_s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // Stage 2: saturating accumulation and window counting. The final sum of a
    // window goes forward to the multiplier; the running sum restarts at zero.
    logic signed [SUM_W-1:0] r_sum  [NPH];
    logic signed [SUM_W-1:0] n_sum  [NPH];
    logic signed [SUM_W-1:0] r_fsum [NPH];
    logic signed [SUM_W-1:0] n_fsum [NPH];
    logic        [CNT_W-1:0] r_cnt;
    logic        [CNT_W-1:0] n_cnt;
    logic                    r_done2;
    logic                    n_done2;

    always_comb begin
        logic signed [SUM_W:0]   acc;
        logic        [CNT_W-1:0] cnt_inc;
        logic        [WIN_W-1:0] len;
        acc     = '0;
        cnt_inc = r_cnt + CNT_W'(1);
        // A zero length acts as one; a length above the largest window is capped.
        len = (r_win_len == '0) ? WIN_W'(1) : r_win_len;
        if ({4'd0, len} > 17'(MAX_WINDOW)) begin
            len = WIN_W'(MAX_WINDOW);
        end
        // The window also closes when the counter wraps, or when the length was
        // lowered below the count mid-window.
        n_done2 = (cnt_inc >= len) || (cnt_inc == '0);
        n_cnt   = n_done2 ? '0 : cnt_inc;
        for (int i = 0; i < NPH; i++) begin
            acc = {r_sum[i][SUM_W-1], r_sum[i]} + (SUM_W+1)'(r_smp[i]);
            if (acc[SUM_W] != acc[SUM_W-1]) begin
                n_fsum[i] = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                n_fsum[i] = acc[SUM_W-1:0];
            end
            n_sum[i] = n_done2 ? '0 : n_fsum[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < NPH; i++) begin
                r_sum[i] <= '0;
            end
        end else if (adv2 && r_v1) begin
            r_cnt <= n_cnt;
            for (int i = 0; i < NPH; i++) begin
                r_sum[i] <= n_sum[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_done2 <= n_done2;
            for (int i = 0; i < NPH; i++) begin
                r_fsum[i] <= n_fsum[i];
            end
        end
    end

    // Stage 3: scale each final sum by the Q0.16 reciprocal.
    logic signed [PROD_W-1:0] r_prod [NPH];
    logic                     r_done3;

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r_done3 <= r_done2;
            for (int i = 0; i < NPH; i++) begin
                r_prod[i] <= PROD_W'(r_fsum[i]) * PROD_W'($signed({1'b0, r_inv_win}));
            end
        end
    end

    // Stage 4: round to nearest with ties upward (add half, then floor), and
    // saturate to the sample range.
    logic signed [SAMPLE_BITS-1:0] r_cand [NPH];
    logic signed [SAMPLE_BITS-1:0] n_cand [NPH];
    logic                          r_done4;

    always_comb begin
        logic signed [PROD_W-1:0] q;
        logic signed [SUM_W:0]    rq;
        q  = '0;
        rq = '0;
        for (int i = 0; i < NPH; i++) begin
            q  = r_prod[i] + PROD_W'(32768);
            rq = q[PROD_W-1:RND_SHIFT];
            if (rq > MEAN_HI) begin
                n_cand[i] = MEAN_HI[SAMPLE_BITS-1:0];
            end else if (rq < MEAN_LO) begin
                n_cand[i] = MEAN_LO[SAMPLE_BITS-1:0];
            end else begin
                n_cand[i] = rq[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4 && r_v3) begin
            r_done4 <= r_done3;
            for (int i = 0; i < NPH; i++) begin
                r_cand[i] <= n_cand[i];
            end
        end
    end

    // Stage 5: update the held means on a window close, then run the threshold
    // test and on-delay timer with the fresh means. The registers here are also
    // the output beat.
    logic signed [SAMPLE_BITS-1:0] r_held  [NPH];
    logic signed [SAMPLE_BITS-1:0] n_held  [NPH];
    logic        [DLY_W-1:0]       r_pcnt  [NPH];
    logic        [DLY_W-1:0]       n_pcnt  [NPH];
    logic        [NPH-1:0]         r_fault;
    logic        [NPH-1:0]         n_fault;
    logic                          r_done5;

    always_comb begin
        logic timer_hit;
        timer_hit = 1'b0;
        for (int i = 0; i < NPH; i++) begin
            n_held[i] = r_done4 ? r_cand[i] : r_held[i];
            if (32'(n_held[i]) > 32'(r_mean_thr)) begin
                n_pcnt[i] = (r_pcnt[i] < r_delay) ? r_pcnt[i] + DLY_W'(1) : r_pcnt[i];
                timer_hit = (n_pcnt[i] >= r_delay);
            end else begin
                n_pcnt[i] = '0;
                timer_hit = 1'b0;
            end
            n_fault[i] = r_fault[i] || timer_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
            for (int i = 0; i < NPH; i++) begin
                r_held[i] <= '0;
                r_pcnt[i] <= '0;
            end
        end else if (adv5 && r_v4) begin
            r_fault <= n_fault;
            for (int i = 0; i < NPH; i++) begin
                r_held[i] <= n_held[i];
                r_pcnt[i] <= n_pcnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5 && r_v4) begin
            r_done5 <= r_done4;
        end
    end

    assign o_m_tvalid = r_v5;
    assign o_m_tuser  = r_done5;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_fault,
                         MEAN_W'(r_held[2]), MEAN_W'(r_held[1]), MEAN_W'(r_held[0])};

    // A result beat that waits on the output keeps its contents until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("waiting result beat changed before it was taken");

    a_fault_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != '0) |=> ((r_fault & $past(r_fault)) == $past(r_fault)))
        else $error("sticky fault bit cleared without reset");

    // The input side only stalls when every stage holds a beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_m_tready))
        else $error("input stalled while the pipeline has room");

    // Fault bits only change when a beat moves into the output register.
    a_fault_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != $past(r_fault)) |-> $past(adv5 && r_v4))
        else $error("fault changed without a beat entering the output stage");

endmodule

// File: verif/phase_current_dc_offset_monitor_tb.sv
// Self-checking testbench for phase_current_dc_offset_monitor.
// Depends on rtl/pcdom_pkg.sv and rtl/phase_current_dc_offset_monitor.sv.
`timescale 1ns / 1ps

module phase_current_dc_offset_monitor_tb;

    import pcdom_pkg::*;

    localparam int CUR_W        = 16;
    localparam int IN_W         = ((NPH * CUR_W + 7) / 8) * 8;
    localparam int OUT_W        = 56;
    localparam int MAX_WIN      = 4096;
    localparam int RANDOM_BEATS = 1050;
    localparam int LONG_BEATS   = 150;   // samples into one oversized window
    localparam int HOLD_CYCLES  = 64;    // long back-pressure stretch on the result side
    localparam int STALL_LIMIT  = 1000;  // cycles with no beat moving before giving up
    localparam int DRAIN_CYCLES = 10;

    localparam logic [CUR_W-1:0] CUR_MAX = 16'h7FFF;
    localparam logic [CUR_W-1:0] CUR_MIN = 16'h8000;

    // Scoreboard: keeps a copy of the monitor state, predicts one result per
    // sample beat and checks result beats against the oldest prediction.
    class offset_scoreboard;
        typedef struct packed {
            logic                           window_done;
            logic [NPH-1:0]                 fault;
            logic [NPH-1:0][MEAN_W-1:0]     mean;
        } result_t;

        logic [WIN_W-1:0]          win_len;
        logic [INV_W-1:0]          inv_win;
        logic signed [THR_W-1:0]   mean_thr;
        logic [DLY_W-1:0]          delay_len;

        logic signed [SUM_W-1:0]   phase_sum [NPH];
        logic [CNT_W-1:0]          sample_cnt;
        logic signed [MEAN_W-1:0]  held_mean [NPH];
        logic [DLY_W-1:0]          persist_cnt [NPH];
        logic [NPH-1:0]            timer_on;
        logic [NPH-1:0]            fault_flag;

        result_t expected_results [$];
        int      mismatch_count;
        int      windows_closed;

        function new();
            win_len        = WIN_LEN_RST;
            inv_win        = INV_WIN_RST;
            mean_thr       = MEAN_THR_RST;
            delay_len      = DELAY_RST;
            sample_cnt     = '0;
            timer_on       = '0;
            fault_flag     = '0;
            mismatch_count = 0;
            windows_closed = 0;
            for (int i = 0; i < NPH; i++) begin
                phase_sum[i]   = '0;
                held_mean[i]   = '0;
                persist_cnt[i] = '0;
            end
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_WIN_LEN:  win_len   = value[WIN_W-1:0];
                CFG_INV_WIN:  inv_win   = value[INV_W-1:0];
                CFG_MEAN_THR: mean_thr  = value[THR_W-1:0];
                CFG_DELAY:    delay_len = value[DLY_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // One accepted sample beat: accumulate, maybe close the window, then
        // run the threshold tests and on-delay timers on the held means.
        function void note_sample(logic [NPH-1:0][CUR_W-1:0] cur);
            longint  acc;
            longint  prod;
            int      eff_len;
            result_t want;

            if (win_len == 0)
                eff_len = 1;
            else if (win_len > MAX_WIN)
                eff_len = MAX_WIN;
            else
                eff_len = int'(win_len);

            for (int i = 0; i < NPH; i++) begin
                acc = longint'(phase_sum[i]) + longint'($signed(cur[i]));
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                else if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                phase_sum[i] = acc[SUM_W-1:0];
            end

            sample_cnt = sample_cnt + 1'b1;
            want.window_done = (sample_cnt >= eff_len) || (sample_cnt == 0);
            if (want.window_done) begin
                sample_cnt = '0;
                for (int i = 0; i < NPH; i++) begin
                    // Round to nearest with ties upward: add half, then floor.
                    prod = longint'(phase_sum[i]) * longint'(inv_win) + 64'sd32768;
                    prod = prod >>> RND_SHIFT;
                    if (prod > 64'sd32767)
                        prod = 64'sd32767;
                    else if (prod < -64'sd32768)
                        prod = -64'sd32768;
                    held_mean[i] = prod[MEAN_W-1:0];
                    phase_sum[i] = '0;
                end
            end

            for (int i = 0; i < NPH; i++) begin
                if (held_mean[i] > mean_thr) begin
                    if (persist_cnt[i] < delay_len)
                        persist_cnt[i] = persist_cnt[i] + 1'b1;
                    timer_on[i] = (persist_cnt[i] >= delay_len);
                end else begin
                    persist_cnt[i] = '0;
                    timer_on[i]    = 1'b0;
                end
                if (timer_on[i])
                    fault_flag[i] = 1'b1;
                want.mean[i] = held_mean[i];
            end
            want.fault = fault_flag;
            expected_results.push_back(want);
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic done);
            result_t                    want;
            logic [NPH-1:0][MEAN_W-1:0] got_mean;
            logic [NPH-1:0]             got_fault;

            got_mean  = data[NPH*MEAN_W-1:0];
            got_fault = data[NPH*MEAN_W +: NPH];
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with no sample behind it, expected none, actual tdata=%h",
                         $time, data);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            for (int i = 0; i < NPH; i++) begin
                if (got_mean[i] !== want.mean[i]) begin
                    $display("%0t: mean of phase %0d (0 is a), expected %0d, actual %0d",
                             $time, i, $signed(want.mean[i]), $signed(got_mean[i]));
                    mismatch_count++;
                end
                if (got_fault[i] !== want.fault[i]) begin
                    $display("%0t: fault of phase %0d (0 is a), expected %b, actual %b",
                             $time, i, want.fault[i], got_fault[i]);
                    mismatch_count++;
                end
            end
            if (done !== want.window_done) begin
                $display("%0t: window_done, expected %b, actual %b",
                         $time, want.window_done, done);
                mismatch_count++;
            end
            if (want.window_done)
                windows_closed++;
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_W-1:0]         i_s_tdata;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_W-1:0]        o_m_tdata;
    logic                    o_m_tuser;
    logic                    i_cfg_we;
    logic [CFG_AW-1:0]       i_cfg_addr;
    logic [CFG_W-1:0]        i_cfg_wdata;

    offset_scoreboard sb;

    // Shared between the stimulus and the result sink, plus run counters.
    bit no_gaps;        // when set, neither side idles between beats
    bit hold_request;   // asks the result sink for one long stall
    int long_holds;
    int beats_sent;
    int programmings;

    phase_current_dc_offset_monitor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one sample beat after a random gap and hold it until accepted.
    // The prediction is made here, at the edge that accepts the beat.
    task automatic send_currents(logic [CUR_W-1:0] ia, logic [CUR_W-1:0] ib,
                                 logic [CUR_W-1:0] ic);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {ic, ib, ia};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample({ic, ib, ia});
        beats_sent++;
    endtask

    // Stop offering samples and wait until every predicted result came back.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; only called while idle.
    task automatic program_monitor(logic [WIN_W-1:0] win, logic [INV_W-1:0] inv,
                                   logic [THR_W-1:0] thr, logic [DLY_W-1:0] dly);
        t_cfg_idx         order [4];
        logic [CFG_W-1:0] value [4];
        order = '{CFG_WIN_LEN, CFG_INV_WIN, CFG_MEAN_THR, CFG_DELAY};
        value = '{CFG_W'(win), inv, thr, dly};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= order[k];
            i_cfg_wdata <= value[k];
            @(posedge i_clk);
            sb.set_register(order[k], value[k]);
        end
        i_cfg_we <= 1'b0;
        programmings++;
    endtask

    // A sample around a per-phase DC level, or a fully random one.
    function automatic logic [CUR_W-1:0] draw_current(int level, int spread, bit wild);
        int v;
        if (wild)
            return CUR_W'($urandom);
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[CUR_W-1:0];
    endfunction

    // Result sink: random ready gaps, plus a long stall whenever asked. While
    // it stalls for HOLD_CYCLES the sender keeps offering, so all five stages
    // fill and the input side has to stall too.
    initial begin : result_sink
        int gap;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                long_holds++;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Every result beat is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
    end

    // Watchdog: a hang shows up as a long run of edges where no beat moves on
    // either stream.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles, %0d results still outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("phase_current_dc_offset_monitor regression: fail");
        $finish;
    end

    initial begin : stimulus
        int               random_beats;
        int               phase_no;
        int               eff;
        int               beats;
        int               spread;
        int               level [NPH];
        bit               wild;
        logic [WIN_W-1:0] win;
        logic [INV_W-1:0] inv;
        logic [THR_W-1:0] thr;
        logic [DLY_W-1:0] dly;

        sb           = new();
        random_beats = 0;
        phase_no     = 0;
        beats_sent   = 0;
        programmings = 0;
        long_holds   = 0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= CFG_WIN_LEN;
        i_cfg_wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero window length acts as one, so every beat closes a window and the
        // mean tracks the sample. Sample extremes and alternating bit patterns.
        // A threshold at the top of the range keeps every fault clear.
        program_monitor('0, 16'hFFFF, CUR_MAX, '0);
        send_currents(CUR_MAX, CUR_MIN, 16'h0000);
        send_currents(CUR_MIN, CUR_MAX, 16'hFFFF);
        send_currents(16'h5555, 16'hAAAA, 16'h0001);
        send_currents(16'hAAAA, 16'h5555, CUR_MAX);
        wait_for_results();

        // Four full-scale samples with a unit scale factor drive each mean
        // past the 16 bit range, so it must saturate high and low.
        program_monitor(13'd4, 16'hFFFF, CUR_MAX, '0);
        repeat (4) send_currents(CUR_MAX, CUR_MIN, CUR_MAX);
        wait_for_results();

        // Window cut short: three samples into a window of ten, the length
        // drops to two and the very next sample must close the window.
        program_monitor(13'd10, 16'd6554, CUR_MAX, '0);
        repeat (3) send_currents(16'd1000, -16'sd1000, 16'd5);
        wait_for_results();
        program_monitor(13'd2, 16'd32768, CUR_MAX, '0);
        send_currents(16'd1000, -16'sd1000, 16'd5);
        wait_for_results();

        // On-delay of three ticks on phase a: two ticks above the limit, one
        // below to clear the counter, then three above; the fault sets on the
        // third of those.
        program_monitor(13'd1, 16'hFFFF, 16'd100, 16'd3);
        send_currents(16'd200, 16'd0, 16'd0);
        send_currents(16'd200, 16'd0, 16'd0);
        send_currents(16'd0, 16'd0, 16'd0);
        repeat (3) send_currents(16'd200, 16'd0, 16'd0);
        wait_for_results();

        // Zero delay on phase b: the fault follows the test on the same tick.
        // Phase c sits exactly on the limit, which is not above it.
        program_monitor(13'd1, 16'hFFFF, 16'd100, '0);
        send_currents(16'd0, 16'd0, 16'd0);
        send_currents(16'd0, 16'd200, 16'd0);
        send_currents(16'd0, 16'd0, 16'd100);
        wait_for_results();

        // Random phases: reprogram while idle, then a run of beats around
        // per-phase DC levels (sometimes plain noise). Windows stay short so
        // that plenty of them close; some lengths are oversized or zero.
        while (random_beats < RANDOM_BEATS) begin
            phase_no++;
            no_gaps = ($urandom_range(0, 4) == 0);

            case ($urandom_range(0, 9))
                0:       win = '0;
                1:       win = WIN_W'($urandom_range(MAX_WIN + 1, 8191));
                2, 3:    win = WIN_W'($urandom_range(17, 64));
                default: win = WIN_W'($urandom_range(1, 16));
            endcase
            if (win == 0)
                eff = 1;
            else if (win > MAX_WIN)
                eff = MAX_WIN;
            else
                eff = int'(win);

            case ($urandom_range(0, 7))
                0:       inv = '0;
                1:       inv = '1;
                2:       inv = INV_W'($urandom);
                default: inv = (eff == 1) ? 16'hFFFF : INV_W'(65536 / eff);
            endcase

            // Mostly high limits, so the sticky faults do not all latch early.
            case ($urandom_range(0, 5))
                0:       thr = THR_W'($urandom);
                1:       thr = CUR_MAX;
                default: thr = THR_W'($urandom_range(12000, 32767));
            endcase

            case ($urandom_range(0, 5))
                0:       dly = '0;
                1:       dly = '1;
                2:       dly = DLY_W'($urandom);
                default: dly = DLY_W'($urandom_range(1, 40));
            endcase

            beats = $urandom_range(1, (3 * eff + 4 > 60) ? 60 : 3 * eff + 4);
            if (phase_no % 8 == 1) begin
                hold_request = 1'b1;
                if (beats < 40)
                    beats = 40;
            end

            wild   = ($urandom_range(0, 3) == 0);
            spread = $urandom_range(0, 2000);
            for (int i = 0; i < NPH; i++)
                level[i] = int'($urandom_range(0, 40000)) - 20000;

            program_monitor(win, inv, thr, dly);
            repeat (beats)
                send_currents(draw_current(level[0], spread, wild),
                              draw_current(level[1], spread, wild),
                              draw_current(level[2], spread, wild));
            random_beats += beats;
            wait_for_results();
        end

        // An oversized length is capped at the largest window, so a long run
        // of samples leaves it open while the sums grow large. Shortening the
        // window afterwards closes it on the very next sample.
        no_gaps = ($urandom_range(0, 1) == 0);
        program_monitor('1, 16'd16, CUR_MAX, '1);
        for (int i = 0; i < NPH; i++)
            level[i] = int'($urandom_range(0, 40000)) - 20000;
        repeat (LONG_BEATS)
            send_currents(draw_current(level[0], 3000, 1'b0),
                          draw_current(level[1], 3000, 1'b0),
                          draw_current(level[2], 3000, 1'b0));
        wait_for_results();
        program_monitor(13'd1, 16'd16, CUR_MAX, '1);
        send_currents(draw_current(level[0], 3000, 1'b0),
                      draw_current(level[1], 3000, 1'b0),
                      draw_current(level[2], 3000, 1'b0));
        wait_for_results();

        // Zero scale factor gives zero means, which always exceed the lowest
        // possible limit, so every phase latches its fault after five ticks.
        no_gaps = 1'b0;
        program_monitor(13'd3, '0, CUR_MIN, 16'd5);
        repeat (10)
            send_currents(CUR_W'($urandom), CUR_W'($urandom), CUR_W'($urandom));
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d sample beats over %0d register settings; %0d windows closed.",
                 beats_sent, programmings, sb.windows_closed);
        $display("Output side stalled long %0d times; final sticky faults a/b/c = %b/%b/%b.",
                 long_holds, sb.fault_flag[0], sb.fault_flag[1], sb.fault_flag[2]);
        if (sb.mismatch_count == 0) begin
            $display("phase_current_dc_offset_monitor regression: pass");
        end else begin
            $display("phase_current_dc_offset_monitor regression: fail");
        end
        $finish;
    end

endmodule

// File: phase_current_dc_offset_monitor.f
rtl/pcdom_pkg.sv
rtl/phase_current_dc_offset_monitor.sv
verif/phase_current_dc_offset_monitor_tb.sv
